// ===== rtl/mdb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and saturation helper for the escape-time block.
package mdb_pkg;

  localparam int Width   = 1024;
  localparam int Height  = 1024;
  localparam int MaxIter = 256;

  localparam int QW     = 36;
  localparam int Frac   = 28;
  localparam int ZoomW  = 35;
  localparam int PixW   = 10;
  localparam int CntW   = 9;
  localparam int ProdW  = QW + PixW + 2;
  localparam int SatW   = QW + PixW + 3;
  localparam int NumW   = QW + Frac;
  localparam int MagW   = 2 * QW - Frac;
  localparam int AddrW  = 6;
  localparam int DataW  = 64;
  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);

  localparam logic [2:0] RegStartX = 3'd0;
  localparam logic [2:0] RegStartY = 3'd1;
  localparam logic [2:0] RegEndX   = 3'd2;
  localparam logic [2:0] RegEndY   = 3'd3;
  localparam logic [2:0] RegZoom   = 3'd4;

  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [ProdW-1:0] WidthS  = ProdW'(Width);
  localparam logic signed [ProdW-1:0] HeightS = ProdW'(Height);
  localparam logic [MagW:0] Limit = (MagW+1)'(16) << Frac;

  typedef struct packed {
    logic [PixW-1:0] pixel_x;
    logic [PixW-1:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [CntW-1:0] iter_count;
    logic            inside_set;
  } out_word_t;

  typedef struct packed {
    logic signed [QW-1:0] cr;
    logic signed [QW-1:0] ci;
  } point_t;

  typedef struct packed {
    logic signed [QW-1:0] start_x;
    logic signed [QW-1:0] start_y;
    logic signed [QW-1:0] end_x;
    logic signed [QW-1:0] end_y;
    logic [ZoomW-1:0]     zoom;
  } cfg_t;

  function automatic logic signed [QW-1:0] sat_q(input logic signed [SatW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > SatW'(QMax)) r = QMax;
    else if (v < SatW'(QMin)) r = QMin;
    else r = v[QW-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/mdb_front.sv =====
`timescale 1ns / 1ps
// Front end: maps a pixel to point c with a shared bit-serial divider.
module mdb_front import mdb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word_i,
  output logic     q_push_o,
  input  logic     q_full_i,
  output point_t   q_word_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  localparam int DivCntW = $clog2(NumW);
  localparam logic [NumW-1:0] NegLim = NumW'(1) << (QW-1);
  localparam logic [NumW-1:0] PosLim = NegLim - NumW'(1);

  fstate_e state_q, state_d;
  logic axis_q, axis_d;
  logic [PixW-1:0] py_q, py_d;
  logic signed [QW-1:0] cr_q, cr_d, ci_q, ci_d;
  logic [NumW-1:0] num_q, num_d;
  logic [ZoomW-1:0] rem_q, rem_d;
  logic neg_q, neg_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  logic sel_y, start;
  logic [PixW-1:0] pix;
  logic signed [QW-1:0] s, e, v;
  logic signed [QW:0] diff;
  logic signed [ProdW-1:0] prod, quo;
  logic [QW:0] vneg;
  logic [QW-1:0] mag;
  logic [ZoomW-1:0] z;
  logic [ZoomW:0] t;
  logic ge;
  logic [NumW-1:0] qn;
  logic signed [QW-1:0] res;

  always_comb begin
    sel_y = (state_q == F_DIV);
    pix   = sel_y ? py_q : in_word_i.pixel_x;
    s     = sel_y ? cfg_i.start_y : cfg_i.start_x;
    e     = sel_y ? cfg_i.end_y : cfg_i.end_x;
    diff  = {e[QW-1], e} - {s[QW-1], s};
    prod  = $signed({1'b0, pix}) * diff;
    quo   = sel_y ? (prod / HeightS) : (prod / WidthS);
    v     = sat_q(SatW'(quo) + SatW'(s));
    vneg  = -{v[QW-1], v};
    mag   = v[QW-1] ? vneg[QW-1:0] : v;
    z     = (cfg_i.zoom == '0) ? ZoomW'(1) : cfg_i.zoom;
    t     = {rem_q, num_q[NumW-1]};
    ge    = (t >= {1'b0, z});
    qn    = {num_q[NumW-2:0], ge};
    if (neg_q) res = (qn > NegLim) ? QMin : QW'(~qn + NumW'(1));
    else       res = (qn > PosLim) ? QMax : qn[QW-1:0];
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    py_d    = py_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    num_d   = num_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    start   = 1'b0;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (push) begin
          py_d    = in_word_i.pixel_y;
          axis_d  = 1'b0;
          start   = 1'b1;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        num_d = qn;
        rem_d = ge ? ZoomW'(t - {1'b0, z}) : t[ZoomW-1:0];
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(NumW - 1)) begin
          if (!axis_q) begin
            cr_d   = res;
            axis_d = 1'b1;
            start  = 1'b1;
          end else begin
            ci_d    = res;
            state_d = F_PUSH;
          end
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
    if (start) begin
      num_d = {mag, {Frac{1'b0}}};
      rem_d = '0;
      neg_d = v[QW-1];
      cnt_d = '0;
    end
  end

  assign full     = (state_q != F_IDLE);
  assign q_word_o = '{cr: cr_q, ci: ci_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      axis_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    py_q  <= py_d;
    cr_q  <= cr_d;
    ci_q  <= ci_d;
    num_q <= num_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

endmodule

// ===== rtl/mdb_queue.sv =====
`timescale 1ns / 1ps
// Two-entry register queue of mapped points between front and back.
module mdb_queue import mdb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  point_t word_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output point_t word_o
);

  point_t mem_q [QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0] cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign word_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PtrW'(1);
      if (pop_i) rp_q <= rp_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= word_i;
  end

endmodule

// ===== rtl/mdb_back.sv =====
`timescale 1ns / 1ps
// Back end: z = z*z + c iteration engine and result register.
module mdb_back import mdb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  point_t    q_word_i,
  output logic      q_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_UPD  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_e;

  bstate_e state_q, state_d;
  logic signed [QW-1:0] cr_q, ci_q, zr_q, zi_q, zr_d, zi_d;
  logic [CntW-1:0] n_q, n_d;
  logic [MagW-1:0] rr_q, ii_q;
  logic signed [MagW:0] ri_q;
  logic out_valid_q, out_valid_d, load;
  out_word_t out_q;

  logic [QW:0] nzr, nzi;
  logic [QW-1:0] ar, ai;
  logic [2*QW-1:0] prr, pii, pri;
  logic [MagW:0] esc;
  logic [CntW-1:0] n_inc;
  logic signed [QW-1:0] zr_new, zi_new;

  always_comb begin
    nzr = -{zr_q[QW-1], zr_q};
    nzi = -{zi_q[QW-1], zi_q};
    ar  = zr_q[QW-1] ? nzr[QW-1:0] : zr_q;
    ai  = zi_q[QW-1] ? nzi[QW-1:0] : zi_q;
    prr = ar * ar;
    pii = ai * ai;
    pri = ar * ai;
    esc = {1'b0, rr_q} + {1'b0, ii_q};
    n_inc = n_q + CntW'(1);
    zi_new = sat_q(SatW'(ri_q) + SatW'(ri_q) + SatW'(ci_q));
    zr_new = sat_q($signed(SatW'(rr_q)) - $signed(SatW'(ii_q)) + SatW'(cr_q));
  end

  always_comb begin
    state_d = state_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    n_d     = n_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          zr_d    = '0;
          zi_d    = '0;
          n_d     = '0;
          state_d = B_MUL;
        end
      end
      B_MUL: state_d = B_UPD;
      B_UPD: begin
        if (esc > Limit) begin
          state_d = B_OUT;
        end else begin
          zr_d = zr_new;
          zi_d = zi_new;
          n_d  = n_inc;
          state_d = (n_inc == CntW'(MaxIter)) ? B_OUT : B_MUL;
        end
      end
      B_OUT: begin
        if (!out_valid_q || pop) begin
          load    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
    out_valid_d = (out_valid_q && !pop) || load;
  end

  assign empty      = !out_valid_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q <= zr_d;
    zi_q <= zi_d;
    n_q  <= n_d;
    if (q_pop_o) begin
      cr_q <= q_word_i.cr;
      ci_q <= q_word_i.ci;
    end
    if (state_q == B_MUL) begin
      rr_q <= prr[2*QW-1:Frac];
      ii_q <= pii[2*QW-1:Frac];
      ri_q <= (zr_q[QW-1] ^ zi_q[QW-1]) ? -$signed({1'b0, pri[2*QW-1:Frac]})
                                         : $signed({1'b0, pri[2*QW-1:Frac]});
    end
    if (load) begin
      out_q.iter_count <= n_q;
      out_q.inside_set <= (n_q == CntW'(MaxIter));
    end
  end

endmodule

// ===== rtl/mandelbrot_escape_time_top.sv =====
`timescale 1ns / 1ps
// Mapping runs two 64-step divisions (one per axis) and a queue hand-off; each iteration then
// passes a multiply state and an update state that makes the escape test, and an output state loads the result.
// The front can take a new pixel once its point is pushed into the queue, the mapping divider
// overlapping the iteration of the previous pixel through a two-entry point queue.
// The iteration engine runs each z*z+c step on three 36x36 multipliers.
// Reset is asynchronous, active low; it empties queue and result and loads default plot.
module mandelbrot_escape_time_top import mdb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  in_word_t         in_word_i,
  output logic             empty,
  input  logic             pop,
  output out_word_t        out_word_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg_q;
  logic wr;
  logic [2:0] idx;
  logic fq_push, fq_full, bq_pop, bq_empty;
  point_t fq_word, bq_word;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x <= -36'sd939524096;
      cfg_q.start_y <= -36'sd805306368;
      cfg_q.end_x   <= 36'sd671088640;
      cfg_q.end_y   <= 36'sd805306368;
      cfg_q.zoom    <= 35'd268435456;
    end else if (wr) begin
      case (idx)
        RegStartX: cfg_q.start_x <= pwdata[QW-1:0];
        RegStartY: cfg_q.start_y <= pwdata[QW-1:0];
        RegEndX:   cfg_q.end_x   <= pwdata[QW-1:0];
        RegEndY:   cfg_q.end_y   <= pwdata[QW-1:0];
        RegZoom:   cfg_q.zoom    <= pwdata[ZoomW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegStartX: prdata = DataW'(cfg_q.start_x);
      RegStartY: prdata = DataW'(cfg_q.start_y);
      RegEndX:   prdata = DataW'(cfg_q.end_x);
      RegEndY:   prdata = DataW'(cfg_q.end_y);
      RegZoom:   prdata = DataW'(cfg_q.zoom);
      default:   prdata = '0;
    endcase
  end

  mdb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push      (push),
    .full      (full),
    .in_word_i (in_word_i),
    .q_push_o  (fq_push),
    .q_full_i  (fq_full),
    .q_word_o  (fq_word)
  );

  mdb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .word_i  (fq_word),
    .full_o  (fq_full),
    .pop_i   (bq_pop),
    .empty_o (bq_empty),
    .word_o  (bq_word)
  );

  mdb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (bq_empty),
    .q_word_i   (bq_word),
    .q_pop_o    (bq_pop),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_word_o.inside_set == (out_word_o.iter_count == CntW'(MaxIter))))
    else $error("inside flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_word_o.iter_count <= CntW'(MaxIter)))
    else $error("iteration count above limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front took a word but did not go busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_push |-> !fq_full) and (bq_pop |-> !bq_empty))
    else $error("point queue overrun or underrun");

endmodule
